// ===== src/salc_pkg.sv =====
// Shared constants and types for the set-associative LRU cache tag model.
package salc_pkg;

   localparam int DEF_MAX_SET_BITS = 10;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_ADDR_BITS    = 64;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 104;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CMP_W      = 5;

   localparam logic [1:0] OP_LOAD_STORE = 2'd0;
   localparam logic [1:0] OP_MODIFY     = 2'd1;

   localparam logic [1:0] REG_SET_INDEX_BITS    = 2'd0;
   localparam logic [1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS_IN_USE       = 2'd2;

   localparam logic [3:0] RST_SET_INDEX_BITS    = 4'd4;
   localparam logic [5:0] RST_BLOCK_OFFSET_BITS = 6'd4;
   localparam logic [3:0] RST_WAYS_IN_USE       = 4'd1;

   typedef struct packed {
      logic [3:0] set_index_bits;
      logic [5:0] block_offset_bits;
      logic [3:0] ways_in_use;
   } csr_regs_type;

   typedef struct packed {
      logic       hit;
      logic       evicted;
      logic [2:0] way_used;
   } access_result_type;

endpackage

// ===== src/salc_csr.sv =====
// Configuration register file with an APB-style access port.
module salc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [salc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [salc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [salc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output salc_pkg::csr_regs_type         regs
);
   import salc_pkg::*;

   csr_regs_type regs_ff, regs_in;
   logic         wr_en;
   logic [1:0]   reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SET_INDEX_BITS:    regs_in.set_index_bits    = csr_pwdata[3:0];
            REG_BLOCK_OFFSET_BITS: regs_in.block_offset_bits = csr_pwdata[5:0];
            REG_WAYS_IN_USE:       regs_in.ways_in_use       = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx)
         REG_SET_INDEX_BITS:    csr_prdata = 32'(regs_ff.set_index_bits);
         REG_BLOCK_OFFSET_BITS: csr_prdata = 32'(regs_ff.block_offset_bits);
         REG_WAYS_IN_USE:       csr_prdata = 32'(regs_ff.ways_in_use);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.set_index_bits    <= RST_SET_INDEX_BITS;
         regs_ff.block_offset_bits <= RST_BLOCK_OFFSET_BITS;
         regs_ff.ways_in_use       <= RST_WAYS_IN_USE;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

// ===== src/salc_mem.sv =====
// Set-row memory: one write port, one read port, registered read data.
module salc_mem #(
   parameter int ADDR_W = salc_pkg::DEF_MAX_SET_BITS,
   parameter int ROW_W  = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ROW_W-1:0]  rd_data
);
   import salc_pkg::*;

   logic [ROW_W-1:0] mem [2**ADDR_W];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/salc_way.sv =====
// Way search, victim choice and age update for one set row.
module salc_way #(
   parameter int MAX_WAYS  = salc_pkg::DEF_MAX_WAYS,
   parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS,
   parameter int AGE_W     = 3,
   parameter int WAY_W     = 3,
   parameter int ENTRY_W   = 1 + 3 + 64
) (
   input  logic [MAX_WAYS-1:0][ENTRY_W-1:0] row,
   input  logic [ADDR_BITS-1:0]             tag,
   input  logic [3:0]                       ways_in_use,
   output logic [MAX_WAYS-1:0][ENTRY_W-1:0] new_row,
   output salc_pkg::access_result_type      result
);
   import salc_pkg::*;

   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   logic [CMP_W-1:0] ways_eff;
   logic             hit, empty_found, best_found;
   logic [WAY_W-1:0] hit_way, empty_way, victim, way;
   logic [AGE_W-1:0] best_age, old_age, cur_age;
   logic [31:0]      way32;

   function automatic logic [AGE_W-1:0] age_bump(input logic [AGE_W-1:0] a);
      return (a >= AGE_MAX) ? AGE_MAX : a + AGE_W'(1);
   endfunction

   always_comb begin
      if (ways_in_use == '0) begin
         ways_eff = CMP_W'(1);
      end else if ({1'b0, ways_in_use} > CMP_W'(MAX_WAYS)) begin
         ways_eff = CMP_W'(MAX_WAYS);
      end else begin
         ways_eff = {1'b0, ways_in_use};
      end
   end

   always_comb begin
      hit         = 1'b0;
      hit_way     = '0;
      empty_found = 1'b0;
      empty_way   = '0;
      best_found  = 1'b0;
      best_age    = '0;
      victim      = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (CMP_W'(w) < ways_eff && !hit) begin
            if (row[w][ENTRY_W-1]) begin
               if (row[w][ADDR_BITS-1:0] == tag) begin
                  hit     = 1'b1;
                  hit_way = WAY_W'(w);
               end else if (!best_found || row[w][ADDR_BITS +: AGE_W] > best_age) begin
                  best_found = 1'b1;
                  best_age   = row[w][ADDR_BITS +: AGE_W];
                  victim     = WAY_W'(w);
               end
            end else if (!empty_found) begin
               empty_found = 1'b1;
               empty_way   = WAY_W'(w);
            end
         end
      end
   end

   assign way     = hit ? hit_way : (empty_found ? empty_way : victim);
   assign old_age = row[way][ADDR_BITS +: AGE_W];

   always_comb begin
      new_row = row;
      cur_age = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         cur_age = row[w][ADDR_BITS +: AGE_W];
         if (CMP_W'(w) < ways_eff && WAY_W'(w) != way && row[w][ENTRY_W-1]
             && (!hit || cur_age < old_age)) begin
            new_row[w][ADDR_BITS +: AGE_W] = age_bump(cur_age);
         end
      end
      new_row[way] = {1'b1, {AGE_W{1'b0}}, tag};
   end

   assign way32           = 32'(way);
   assign result.hit      = hit;
   assign result.evicted  = !hit && !empty_found;
   assign result.way_used = way32[2:0];

endmodule

// ===== src/set_assoc_lru_cache_tag_model.sv =====
// A request is accepted in S_IDLE, its set row read into the memory's read register;
// the result is registered in S_ACCESS once the response slot is free. A modify's
// second result comes from a second S_ACCESS pass that reuses the row its first wrote.
// A new request is taken only in S_IDLE; ops other than load/store and modify get no
// access and no response. Reset: synchronous; a clearing pass zeroes all the
// 2**MAX_SET_BITS set rows (1024 by default) while req_tready stays low.
module set_assoc_lru_cache_tag_model #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
   parameter int ADDR_BITS    = salc_pkg::DEF_ADDR_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [63:0] address, [65:64] op, [71:66] zero
   input  logic [salc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] hit, [1] evicted, [4:2] way_used, [36:5] hits_total,
   // [68:37] misses_total, [100:69] evictions_total, [103:101] zero
   output logic [salc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [salc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [salc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [salc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import salc_pkg::*;

   localparam int SET_W   = MAX_SET_BITS;
   localparam int AGE_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int ENTRY_W = 1 + AGE_W + ADDR_BITS;
   localparam int ROW_W   = MAX_WAYS * ENTRY_W;

   typedef enum logic [2:0] {
      S_CLEAR  = 3'b001,
      S_IDLE   = 3'b010,
      S_ACCESS = 3'b100
   } state_type;

   state_type state_ff, state_in;

   csr_regs_type      regs;
   access_result_type result;

   logic [ADDR_BITS-1:0] req_addr, req_shifted, req_tag;
   logic [1:0]           req_op;
   logic [CMP_W-1:0]     sb_eff;
   logic [6:0]           tag_shift;
   logic [SET_W-1:0]     set_mask, req_set;
   logic                 req_fire, acc_fire, clearing;

   logic [ADDR_BITS-1:0] tag_ff, tag_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [SET_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                 second_ff, second_in;
   logic                 use_fwd_ff, use_fwd_in;
   logic [ROW_W-1:0]     fwd_row_ff, fwd_row_in;
   logic [31:0]          hits_ff, hits_in, misses_ff, misses_in, evicts_ff, evicts_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [ROW_W-1:0] mem_rdata, row_cur, row_new;
   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   logic [ROW_W-1:0] mem_wdata;

   salc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   // request decode: set index and tag
   assign req_addr    = req_tdata[ADDR_BITS-1:0];
   assign req_op      = req_tdata[65:64];
   assign sb_eff      = ({1'b0, regs.set_index_bits} > CMP_W'(MAX_SET_BITS)) ?
                        CMP_W'(MAX_SET_BITS) : {1'b0, regs.set_index_bits};
   assign tag_shift   = 7'(sb_eff) + 7'(regs.block_offset_bits);
   assign req_shifted = req_addr >> regs.block_offset_bits;
   assign set_mask    = ~({SET_W{1'b1}} << sb_eff);
   assign req_set     = req_shifted[SET_W-1:0] & set_mask;
   assign req_tag     = req_addr >> tag_shift;

   assign clearing   = (state_ff == S_CLEAR);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign acc_fire   = (state_ff == S_ACCESS) && (!rsp_valid_ff || rsp_tready);

   assign mem_we    = clearing || acc_fire;
   assign mem_waddr = clearing ? clr_cnt_ff : set_ff;
   assign mem_wdata = clearing ? '0 : row_new;

   salc_mem #(
      .ADDR_W (SET_W),
      .ROW_W  (ROW_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_set),
      .rd_data (mem_rdata)
   );

   assign row_cur = use_fwd_ff ? fwd_row_ff : mem_rdata;

   salc_way #(
      .MAX_WAYS  (MAX_WAYS),
      .ADDR_BITS (ADDR_BITS),
      .AGE_W     (AGE_W),
      .WAY_W     (WAY_W),
      .ENTRY_W   (ENTRY_W)
   ) u_way (
      .row         (row_cur),
      .tag         (tag_ff),
      .ways_in_use (regs.ways_in_use),
      .new_row     (row_new),
      .result      (result)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      tag_in       = tag_ff;
      set_in       = set_ff;
      second_in    = second_ff;
      use_fwd_in   = use_fwd_ff;
      fwd_row_in   = fwd_row_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + SET_W'(1);
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               tag_in     = req_tag;
               set_in     = req_set;
               use_fwd_in = 1'b0;
               second_in  = (req_op == OP_MODIFY);
               if (req_op == OP_LOAD_STORE || req_op == OP_MODIFY) begin
                  state_in = S_ACCESS;
               end
            end
         end
         S_ACCESS: begin
            if (acc_fire) begin
               hits_in      = hits_ff + 32'(result.hit);
               misses_in    = misses_ff + 32'(!result.hit);
               evicts_in    = evicts_ff + 32'(result.evicted);
               rsp_valid_in = 1'b1;
               rsp_last_in  = !second_ff;
               rsp_data_in  = {3'b000, evicts_in, misses_in, hits_in,
                               result.way_used, result.evicted, result.hit};
               if (second_ff) begin
                  second_in  = 1'b0;
                  use_fwd_in = 1'b1;
                  fwd_row_in = row_new;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         second_ff    <= 1'b0;
         use_fwd_ff   <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         second_ff    <= second_in;
         use_fwd_ff   <= use_fwd_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tag_ff      <= tag_in;
      set_ff      <= set_in;
      fwd_row_ff  <= fwd_row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_one_count_per_access: assert property (@(posedge clock) disable iff (reset)
      acc_fire |=> (hits_ff + misses_ff) == $past(hits_ff + misses_ff) + 32'd1)
      else $error("hit plus miss total did not advance by one");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result marks both hit and eviction");

   a_last_access_returns_idle: assert property (@(posedge clock) disable iff (reset)
      acc_fire && !second_ff |=> state_ff == S_IDLE && rsp_tlast)
      else $error("final access did not close the request");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !second_ff && state_ff == S_IDLE)
      else $error("request taken during access or clearing");
`endif

endmodule

// ===== tb/sv/set_assoc_lru_cache_tag_model_test.sv =====
// Self-checking stream testbench for the set-associative LRU cache tag model.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tag_model_test;
   import salc_pkg::*;

   localparam int SETS_MAX_BITS = DEF_MAX_SET_BITS;
   localparam int WAYS_MAX      = DEF_MAX_WAYS;
   localparam int SLOT_COUNT    = (1 << SETS_MAX_BITS) * WAYS_MAX;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [1:0] OP_FETCH  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [63:0] address;
      logic [1:0]  op;
   } cache_request_type;

   typedef struct packed {
      bit        hit;
      bit        evicted;
      bit [2:0]  way;
      bit [31:0] hits;
      bit [31:0] misses;
      bit [31:0] evictions;
      bit        closes;
   } cache_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [63:0] address, [65:64] op, [71:66] zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] hit, [1] evicted, [4:2] way_used, [36:5] hits_total,
   // [68:37] misses_total, [100:69] evictions_total, [103:101] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   set_assoc_lru_cache_tag_model DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // predicted cache contents
   bit          slot_valid [SLOT_COUNT];
   logic [63:0] slot_tag   [SLOT_COUNT];
   bit [2:0]    slot_rank  [SLOT_COUNT];
   bit [31:0]   hits_seen, misses_seen, evict_count;
   bit [3:0]    cfg_set_bits    = RST_SET_INDEX_BITS;
   bit [5:0]    cfg_offset_bits = RST_BLOCK_OFFSET_BITS;
   bit [3:0]    cfg_ways        = RST_WAYS_IN_USE;

   cache_request_type request_backlog[$];
   cache_outcome_type outcomes_due[$];
   logic [63:0]       recent_addresses[$];
   int                pushed_count, accepted_count, fail_count, cycle_count;
   bit                req_idle_on = 1'b1;
   bit                rsp_idle_on = 1'b1;
   int                hold_left, holds_done;

   function automatic bit [2:0] rank_up(bit [2:0] a);
      return (a >= 3'(WAYS_MAX - 1)) ? 3'(WAYS_MAX - 1) : a + 3'd1;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic cache_access(logic [63:0] address, bit closes);
      int unsigned       sb, bb, ways, shift, set, base, w, way, empty, victim;
      int                best;
      logic [63:0]       tag;
      bit [2:0]          old_rank;
      bit                hit, evict;
      cache_outcome_type o;
      sb = (cfg_set_bits > SETS_MAX_BITS) ? SETS_MAX_BITS : cfg_set_bits;
      bb = cfg_offset_bits;
      ways = cfg_ways;
      if (ways < 1) ways = 1;
      if (ways > WAYS_MAX) ways = WAYS_MAX;
      shift = sb + bb;
      tag = (shift >= 64) ? 64'd0 : (address >> shift);
      set = 32'((address >> bb) & ((64'd1 << sb) - 64'd1));
      base = set * WAYS_MAX;
      way = 0;
      empty = WAYS_MAX;
      victim = 0;
      best = -1;
      hit = 1'b0;
      evict = 1'b0;
      for (w = 0; w < ways; w++) begin
         if (slot_valid[base + w]) begin
            if (slot_tag[base + w] == tag) begin
               hit = 1'b1;
               way = w;
               break;
            end
            if (int'(slot_rank[base + w]) > best) begin
               best = slot_rank[base + w];
               victim = w;
            end
         end else if (empty == WAYS_MAX) begin
            empty = w;
         end
      end
      if (hit) begin
         old_rank = slot_rank[base + way];
         hits_seen++;
         for (w = 0; w < ways; w++)
            if (w != way && slot_valid[base + w] && slot_rank[base + w] < old_rank)
               slot_rank[base + w] = rank_up(slot_rank[base + w]);
      end else begin
         misses_seen++;
         if (empty != WAYS_MAX) begin
            way = empty;
         end else begin
            way = victim;
            evict = 1'b1;
            evict_count++;
         end
         for (w = 0; w < ways; w++)
            if (w != way && slot_valid[base + w])
               slot_rank[base + w] = rank_up(slot_rank[base + w]);
         slot_valid[base + way] = 1'b1;
         slot_tag[base + way] = tag;
      end
      slot_rank[base + way] = 3'd0;
      o.hit = hit;
      o.evicted = evict;
      o.way = way[2:0];
      o.hits = hits_seen;
      o.misses = misses_seen;
      o.evictions = evict_count;
      o.closes = closes;
      outcomes_due.push_back(o);
   endtask

   // request driver
   int gap_left;
   cache_request_type in_flight;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (in_flight.op == OP_LOAD_STORE) begin
               cache_access(in_flight.address, 1'b1);
            end else if (in_flight.op == OP_MODIFY) begin
               cache_access(in_flight.address, 1'b0);
               cache_access(in_flight.address, 1'b1);
            end
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               in_flight = request_backlog.pop_front();
               req_tdata <= {6'd0, in_flight.op, in_flight.address};
               req_tvalid <= 1'b1;
               gap_left = req_idle_on ? draw_gap() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-offs so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && accepted_count >= 300) ||
                   (holds_done == 1 && accepted_count >= 1100)) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // response monitor
   int stall_left;
   always @(posedge clock) begin
      cache_outcome_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcomes_due.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = outcomes_due.pop_front();
               check_field("hit", want.hit, rsp_tdata[0]);
               check_field("evicted", want.evicted, rsp_tdata[1]);
               check_field("way_used", want.way, rsp_tdata[4:2]);
               check_field("hits_total", want.hits, rsp_tdata[36:5]);
               check_field("misses_total", want.misses, rsp_tdata[68:37]);
               check_field("evictions_total", want.evictions, rsp_tdata[100:69]);
               check_field("last", want.closes, rsp_tlast);
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 3) == 0) stall_left = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_request(logic [63:0] address, logic [1:0] op);
      cache_request_type r;
      r.address = address;
      r.op = op;
      request_backlog.push_back(r);
      pushed_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count != pushed_count || outcomes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(bit [3:0] sb, bit [5:0] bb, bit [3:0] ways);
      csr_write(REG_SET_INDEX_BITS, 32'(sb));
      csr_write(REG_BLOCK_OFFSET_BITS, 32'(bb));
      csr_write(REG_WAYS_IN_USE, 32'(ways));
      cfg_set_bits = sb;
      cfg_offset_bits = bb;
      cfg_ways = ways;
   endtask

   // mostly a few hot sets and tags so lines hit, fill and get evicted
   function automatic logic [63:0] pick_address();
      int unsigned r, sb, bb;
      logic [63:0] a;
      r = $urandom_range(0, 99);
      a = {$urandom, $urandom};
      if (r < 15 && recent_addresses.size() != 0)
         return recent_addresses[$urandom_range(0, recent_addresses.size() - 1)];
      if (r >= 25) begin
         sb = (cfg_set_bits > SETS_MAX_BITS) ? SETS_MAX_BITS : cfg_set_bits;
         bb = cfg_offset_bits;
         a = (64'($urandom_range(0, cfg_ways + 2)) << (sb + bb)) |
             (64'($urandom_range(0, 3)) << bb) | (a & ((64'd1 << bb) - 64'd1));
      end
      recent_addresses.push_back(a);
      if (recent_addresses.size() > 8) void'(recent_addresses.pop_front());
      return a;
   endfunction

   initial begin
      int r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one way, every conflict evicts
      queue_request(64'd0, OP_LOAD_STORE);
      queue_request('1, OP_LOAD_STORE);
      queue_request(64'd0, OP_LOAD_STORE);
      queue_request(64'h100, OP_MODIFY);
      queue_request(64'd0, OP_FETCH);
      queue_request('1, OP_UNUSED);
      queue_request(64'd0, OP_LOAD_STORE);
      wait_drained();

      // two ways: hit refreshes recency, miss evicts the older line
      set_config(4'd2, 6'd4, 4'd2);
      queue_request(64'd1 << 6, OP_LOAD_STORE);
      queue_request(64'd2 << 6, OP_LOAD_STORE);
      queue_request(64'd1 << 6, OP_LOAD_STORE);
      queue_request(64'd3 << 6, OP_LOAD_STORE);
      queue_request(64'd2 << 6, OP_MODIFY);
      wait_drained();

      // set bits and ways above their maximum, tag shift past 64
      set_config(4'd15, 6'd60, 4'd15);
      queue_request(64'd0, OP_LOAD_STORE);
      queue_request(64'hF000_0000_0000_0000, OP_LOAD_STORE);
      queue_request(64'h0FFF_FFFF_FFFF_FFFF, OP_LOAD_STORE);
      queue_request(64'hFFFF_FFFF_FFFF_FFFF, OP_MODIFY);
      wait_drained();

      // no set bits: single set; zero ways acts as one
      set_config(4'd0, 6'd8, 4'd0);
      queue_request(64'h100, OP_LOAD_STORE);
      queue_request(64'h1FF, OP_LOAD_STORE);
      queue_request(64'h200, OP_LOAD_STORE);
      queue_request(64'h8000_0000_0000_0000, OP_MODIFY);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         if (p == 0)
            set_config(4'd1, 6'd1, 4'd1);
         else if (p == 1)
            set_config(4'd10, 6'd32, 4'd8);
         else
            set_config(4'($urandom_range(1, 10)), 6'($urandom_range(1, 32)),
                       4'($urandom_range(1, 8)));
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < 204; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
               queue_request(pick_address(), OP_LOAD_STORE);
            else if (r < 90)
               queue_request(pick_address(), OP_MODIFY);
            else if (r < 97)
               queue_request(pick_address(), OP_FETCH);
            else
               queue_request(pick_address(), OP_UNUSED);
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
